/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the sorted set table.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante true -> cons true in the same cycle
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// ante true -> cons true in the next cycle
`define ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// expr holds at every edge
`define ASSERT_ALW(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`endif

/* rtl/sst_pkg.sv */
// Shared constants and types of the sorted set table.
// No dependencies; used by sorted_set_table.
package sst_pkg;

  localparam int CAPACITY = 256;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_DUP    = 3'd1;
  localparam logic [2:0] ST_ABSENT = 3'd2;
  localparam logic [2:0] ST_FULL   = 3'd3;
  localparam logic [2:0] ST_RANGE  = 3'd4;

endpackage

/* rtl/sst_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; instantiated by sorted_set_table.
module sst_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/sorted_set_table.sv */
// Sorted set table: up to 256 signed 32-bit keys held in ascending order in one
// RAM, with insert, delete, lookup and read-by-position commands. One command is
// taken at a time: start is accepted while busy is low, and the single result is
// shown for one cycle with done high; it cannot be held off. Every key command
// first runs a binary search through the RAM, each halving step reading the
// middle entry, then comparing it with the key. Insert then moves the entries
// above the slot up one place and delete moves them down, one entry per cycle
// through the RAM's read and write ports. A read whose position is out of range
// finishes without reading the RAM. The RAM holds no reset state; only entries
// below the count ever reach a result.
// Depends on sst_pkg, sst_ram and assert_macros.svh.
`include "assert_macros.svh"

module sorted_set_table (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           operation,
  input  logic signed [sst_pkg::KEY_W-1:0]     key,
  input  logic [7:0]                           position,
  output logic                                 done,
  output logic [2:0]                           status,
  output logic                                 found,
  output logic signed [sst_pkg::KEY_W-1:0]     entry_value,
  output logic [8:0]                           stored_count
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,
    S_CMP,
    S_EQ,
    S_INS,
    S_DEL,
    S_RDV
  } state_t;

  state_t                          state;
  sst_pkg::op_t                    op_r;
  logic signed [sst_pkg::KEY_W-1:0] key_r;
  logic [sst_pkg::CNT_W-1:0]       count;
  logic [sst_pkg::CNT_W-1:0]       lo;
  logic [sst_pkg::CNT_W-1:0]       hi;
  logic [sst_pkg::CNT_W-1:0]       j;
  logic                            pend;
  logic [sst_pkg::ADDR_W-1:0]      pend_addr;

  logic [sst_pkg::CNT_W:0]         mid_sum;
  logic [sst_pkg::CNT_W-1:0]       mid;
  logic                            hit;
  logic                            accept;

  logic                            we;
  logic [sst_pkg::ADDR_W-1:0]      waddr;
  logic [sst_pkg::KEY_W-1:0]       wdata;
  logic [sst_pkg::ADDR_W-1:0]      raddr;
  logic [sst_pkg::KEY_W-1:0]       rdata;

  assign busy         = (state != S_IDLE);
  assign accept       = start && !busy;
  assign stored_count = count;

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[sst_pkg::CNT_W:1];
  assign hit     = (lo < count) && (rdata == key_r);

  // read address
  always_comb begin
    case (state)
      S_IDLE:  raddr = position[sst_pkg::ADDR_W-1:0];
      S_SRCH:  raddr = (lo < hi) ? mid[sst_pkg::ADDR_W-1:0] : lo[sst_pkg::ADDR_W-1:0];
      S_INS:   raddr = sst_pkg::ADDR_W'(j - sst_pkg::CNT_W'(1));
      S_DEL:   raddr = sst_pkg::ADDR_W'(j + sst_pkg::CNT_W'(1));
      default: raddr = lo[sst_pkg::ADDR_W-1:0];
    endcase
  end

  // write port: pending shift beat, or the new key once the gap is open
  always_comb begin
    we    = 1'b0;
    waddr = pend_addr;
    wdata = rdata;
    if ((state == S_INS || state == S_DEL) && pend) begin
      we = 1'b1;
    end else if (state == S_INS && j == lo) begin
      we    = 1'b1;
      waddr = lo[sst_pkg::ADDR_W-1:0];
      wdata = key_r;
    end
  end

  sst_ram #(
    .DEPTH(sst_pkg::CAPACITY),
    .WIDTH(sst_pkg::KEY_W)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
      pend  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_r        <= sst_pkg::op_t'(operation);
            key_r       <= key;
            lo          <= '0;
            hi          <= count;
            pend        <= 1'b0;
            found       <= 1'b0;
            entry_value <= '0;
            if (sst_pkg::op_t'(operation) == sst_pkg::OP_READ) begin
              if ({1'b0, position} < count) begin
                state <= S_RDV;
              end else begin
                status <= sst_pkg::ST_RANGE;
                done   <= 1'b1;
              end
            end else begin
              state <= S_SRCH;
            end
          end
        end
        S_SRCH: begin
          state <= (lo < hi) ? S_CMP : S_EQ;
        end
        S_CMP: begin
          if ($signed(rdata) < key_r) begin
            lo <= mid + sst_pkg::CNT_W'(1);
          end else begin
            hi <= mid;
          end
          state <= S_SRCH;
        end
        S_EQ: begin
          case (op_r)
            sst_pkg::OP_INSERT: begin
              if (hit) begin
                status <= sst_pkg::ST_DUP;
                found  <= 1'b1;
                done   <= 1'b1;
                state  <= S_IDLE;
              end else if (count == sst_pkg::CNT_W'(sst_pkg::CAPACITY)) begin
                status <= sst_pkg::ST_FULL;
                done   <= 1'b1;
                state  <= S_IDLE;
              end else begin
                j     <= count;
                state <= S_INS;
              end
            end
            sst_pkg::OP_DELETE: begin
              if (hit) begin
                found <= 1'b1;
                j     <= lo;
                state <= S_DEL;
              end else begin
                status <= sst_pkg::ST_ABSENT;
                done   <= 1'b1;
                state  <= S_IDLE;
              end
            end
            default: begin
              found  <= hit;
              status <= hit ? sst_pkg::ST_OK : sst_pkg::ST_ABSENT;
              done   <= 1'b1;
              state  <= S_IDLE;
            end
          endcase
        end
        S_INS: begin
          // walk down: read j-1 now, write it to j next cycle
          if (j > lo) begin
            pend      <= 1'b1;
            pend_addr <= j[sst_pkg::ADDR_W-1:0];
            j         <= j - sst_pkg::CNT_W'(1);
          end else if (pend) begin
            pend <= 1'b0;
          end else begin
            count  <= count + sst_pkg::CNT_W'(1);
            status <= sst_pkg::ST_OK;
            done   <= 1'b1;
            state  <= S_IDLE;
          end
        end
        S_DEL: begin
          // walk up: read j+1 now, write it to j next cycle
          if ((j + sst_pkg::CNT_W'(1)) < count) begin
            pend      <= 1'b1;
            pend_addr <= j[sst_pkg::ADDR_W-1:0];
            j         <= j + sst_pkg::CNT_W'(1);
          end else if (pend) begin
            pend <= 1'b0;
          end else begin
            count  <= count - sst_pkg::CNT_W'(1);
            status <= sst_pkg::ST_OK;
            done   <= 1'b1;
            state  <= S_IDLE;
          end
        end
        S_RDV: begin
          entry_value <= rdata;
          status      <= sst_pkg::ST_OK;
          done        <= 1'b1;
          state       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_IMP(a_done_idle, clk, rst, done, !busy, "result beat while still busy")
  `ASSERT_NXT(a_accept_progress, clk, rst, accept, busy || done, "accepted command stalled")
  `ASSERT_ALW(a_count_cap, clk, rst, count <= sst_pkg::CNT_W'(sst_pkg::CAPACITY), "count over capacity")
  `ASSERT_IMP(a_full_count, clk, rst, done && status == sst_pkg::ST_FULL,
              count == sst_pkg::CNT_W'(sst_pkg::CAPACITY), "full status with room left")

endmodule

/* test/sorted_set_table_tb.sv */
// Self-checking testbench for sorted_set_table: directed and random commands are
// checked against a behavioral model of the sorted key store.
// Depends on sst_pkg and the sorted_set_table RTL.
module sorted_set_table_tb;
  import sst_pkg::*;

  typedef struct packed {
    op_t               op;
    logic signed [31:0] key;
    logic [7:0]        position;
    logic [6:0]        gap_pct;
    logic              drain;
  } table_cmd_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               found;
    logic signed [31:0] entry_value;
    logic [8:0]         stored_count;
  } table_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] operation = OP_INSERT;
  logic signed [31:0] key = '0;
  logic [7:0] position = '0;
  logic busy, done, found;
  logic [2:0] status;
  logic signed [31:0] entry_value;
  logic [8:0] stored_count;

  sorted_set_table dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .key(key), .position(position),
    .done(done), .status(status), .found(found),
    .entry_value(entry_value), .stored_count(stored_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  table_cmd_t    cmd_queue[$];
  table_result_t expected_results[$];
  int            mismatches = 0;
  int            beats_taken = 0;
  int            total_cmds = 0;
  logic          beat_taken = 1'b0;

  // model state: keys in ascending order, slots at or above held_count unused
  logic signed [31:0] held_keys [CAPACITY];
  int                 held_count = 0;

  // keys the stimulus expects to be held, in no order
  logic signed [31:0] plan_keys[$];

  function automatic table_result_t apply_cmd(op_t op, logic signed [31:0] k,
                                              logic [7:0] pos);
    table_result_t r;
    int at;
    int slot;
    r = '0;
    at = -1;
    for (int i = 0; i < held_count; i++)
      if (held_keys[i] == k) at = i;
    case (op)
      OP_INSERT: begin
        if (at >= 0) begin
          r.status = ST_DUP;
          r.found = 1'b1;
        end else if (held_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          slot = 0;
          while (slot < held_count && held_keys[slot] <= k) slot++;
          for (int j = held_count; j > slot; j--) held_keys[j] = held_keys[j-1];
          held_keys[slot] = k;
          held_count++;
        end
      end
      OP_DELETE: begin
        if (at < 0) begin
          r.status = ST_ABSENT;
        end else begin
          r.found = 1'b1;
          for (int j = at; j + 1 < held_count; j++) held_keys[j] = held_keys[j+1];
          held_count--;
        end
      end
      OP_LOOKUP: begin
        if (at >= 0) r.found = 1'b1;
        else r.status = ST_ABSENT;
      end
      default: begin
        if (pos < held_count) r.entry_value = held_keys[pos];
        else r.status = ST_RANGE;
      end
    endcase
    r.stored_count = 9'(held_count);
    return r;
  endfunction

  function automatic int plan_index(logic signed [31:0] k);
    int idx;
    idx = -1;
    foreach (plan_keys[i])
      if (plan_keys[i] == k) idx = i;
    return idx;
  endfunction

  task automatic push_cmd(op_t op, logic signed [31:0] k, logic [7:0] pos,
                          int gap, bit drain = 1'b0);
    table_cmd_t c;
    int idx;
    c.op = op;
    c.key = k;
    c.position = pos;
    c.gap_pct = 7'(gap);
    c.drain = drain;
    cmd_queue.push_back(c);
    total_cmds++;
    idx = plan_index(k);
    if (op == OP_INSERT && idx < 0 && plan_keys.size() < CAPACITY) plan_keys.push_back(k);
    if (op == OP_DELETE && idx >= 0) plan_keys.delete(idx);
  endtask

  // mostly held keys or a narrow band so hits and duplicates are common
  function automatic logic signed [31:0] pick_key();
    int s;
    s = $urandom_range(9);
    if (s < 4 && plan_keys.size() > 0) return plan_keys[$urandom_range(plan_keys.size() - 1)];
    if (s < 7) return 32'(int'($urandom_range(40)) - 20);
    return $urandom;
  endfunction

  function automatic logic [7:0] pick_position();
    if (plan_keys.size() > 0 && $urandom_range(1) == 0)
      return 8'($urandom_range(plan_keys.size() - 1));
    return 8'($urandom_range(255));
  endfunction

  task automatic push_random_cmd(int gap);
    int r;
    op_t op;
    r = $urandom_range(99);
    if (r < 40) op = OP_INSERT;
    else if (r < 60) op = OP_DELETE;
    else if (r < 80) op = OP_LOOKUP;
    else op = OP_READ;
    push_cmd(op, pick_key(), pick_position(), gap);
  endtask

  // driver: a beat is held until taken; the next one may follow on the next cycle
  always @(negedge clk) begin : drive_proc
    logic next_start;
    table_cmd_t c;
    next_start = start;
    if (rst) begin
      next_start = 1'b0;
    end else if (!start || beat_taken) begin
      next_start = 1'b0;
      if (cmd_queue.size() > 0) begin
        c = cmd_queue[0];
        if (!(c.drain && expected_results.size() != 0) &&
            $urandom_range(99) >= c.gap_pct) begin
          void'(cmd_queue.pop_front());
          operation <= c.op;
          key <= c.key;
          position <= c.position;
          next_start = 1'b1;
        end
      end
    end
    start <= next_start;
  end

  task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp, act);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor_proc
    table_result_t e;
    beat_taken <= !rst && start && !busy;
    if (!rst) begin
      if (done) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, status %0d value %h count %0d",
                   $time, status, entry_value, stored_count);
          mismatches++;
        end else begin
          e = expected_results.pop_front();
          check_field("status", 32'(e.status), 32'(status));
          check_field("found", 32'(e.found), 32'(found));
          check_field("entry_value", e.entry_value, entry_value);
          check_field("stored_count", 32'(e.stored_count), 32'(stored_count));
        end
      end
      if (start && !busy) begin
        expected_results.push_back(apply_cmd(op_t'(operation), key, position));
        beats_taken++;
      end
    end
  end

  initial begin
    // directed: empty store, extreme keys, duplicates, ends of the order
    push_cmd(OP_READ, 0, 8'd0, 0);
    push_cmd(OP_READ, 0, 8'd255, 0);
    push_cmd(OP_LOOKUP, 0, 8'd0, 0);
    push_cmd(OP_DELETE, 5, 8'd0, 0);
    push_cmd(OP_INSERT, 32'h7fff_ffff, 8'd0, 0);
    push_cmd(OP_INSERT, 32'h8000_0000, 8'd0, 0);
    push_cmd(OP_INSERT, 0, 8'd0, 0);
    push_cmd(OP_INSERT, -1, 8'd0, 0);
    push_cmd(OP_INSERT, 1, 8'd0, 0);
    push_cmd(OP_INSERT, 0, 8'd0, 0);
    push_cmd(OP_INSERT, 32'h8000_0000, 8'd0, 0);
    push_cmd(OP_LOOKUP, -1, 8'd0, 0);
    push_cmd(OP_LOOKUP, 2, 8'd0, 0);
    push_cmd(OP_READ, 0, 8'd0, 0);
    push_cmd(OP_READ, 0, 8'd4, 0);
    push_cmd(OP_READ, 0, 8'd5, 0);
    push_cmd(OP_DELETE, 0, 8'd0, 0);
    push_cmd(OP_DELETE, 32'h7fff_ffff, 8'd0, 0);
    push_cmd(OP_DELETE, 32'h8000_0000, 8'd0, 0);
    push_cmd(OP_DELETE, 32'h8000_0000, 8'd0, 0);
    push_cmd(OP_READ, 0, 8'd1, 0);
    push_cmd(OP_LOOKUP, 32'h7fff_ffff, 8'd0, 0);

    repeat (120) push_random_cmd(0);
    repeat (80) push_random_cmd(86);

    // fill to capacity, then hit the full store
    while (plan_keys.size() < CAPACITY) push_cmd(OP_INSERT, $urandom, 8'd0, 20);
    repeat (3) push_cmd(OP_INSERT, $urandom, 8'd0, 0);
    push_cmd(OP_INSERT, plan_keys[$urandom_range(CAPACITY - 1)], 8'd0, 0);
    push_cmd(OP_READ, 0, 8'd255, 0);
    push_cmd(OP_READ, 0, 8'd0, 0);
    push_cmd(OP_LOOKUP, pick_key(), 8'd0, 0);

    // delete held keys again, mixed with random commands, starting from a quiet block
    for (int i = 0; i < 150; i++) begin
      if (i == 0 || $urandom_range(99) < 70)
        push_cmd(OP_DELETE, plan_keys[$urandom_range(plan_keys.size() - 1)],
                 8'd0, i < 60 ? 86 : 0, i == 0);
      else
        push_random_cmd(i < 60 ? 86 : 0);
    end

    repeat (80) push_random_cmd(20);

    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (beats_taken != total_cmds || expected_results.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (mismatches == 0)
      $display("sorted_set_table_tb OK");
    else
      $display("sorted_set_table_tb NOT OK");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("sorted_set_table_tb NOT OK");
    $finish;
  end

endmodule

/* sorted_set_table.f */
+incdir+rtl
rtl/sst_pkg.sv
rtl/sst_ram.sv
rtl/sorted_set_table.sv
test/sorted_set_table_tb.sv
